FILE: rtl/isr_pkg.sv
// Shared types and constants for the inverse square root modulo 2^k pipeline.
// No dependencies; used by isr_lift_stage and inverse_square_root_mod_pow2_top.
package isr_pkg;

  localparam int DATA_W = 64;
  localparam int K_W    = 7;
  localparam int K_MIN  = 3;

  // One request on the input side.
  typedef struct packed {
    logic [DATA_W-1:0] square_value;
    logic              last_in_vector;
  } in_t;

  // One result.
  typedef struct packed {
    logic [DATA_W-1:0] inverse_root;
    logic              last_out;
  } out_t;

  // Working set carried from stage to stage.
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [DATA_W-1:0] e;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] sq;
    logic [DATA_W-1:0] p;
  } lane_t;

endpackage

FILE: rtl/isr_lift_stage.sv
// One registered lifting round for bit position J of root and inverse.
// Depends on isr_pkg for the lane type.
module isr_lift_stage #(
  parameter int J = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [isr_pkg::K_W-1:0] k,
  input  isr_pkg::lane_t          lane_in,
  output isr_pkg::lane_t          lane_out
);
  import isr_pkg::*;

  localparam logic [K_W-1:0] JLIM = K_W'(J + 2);

  logic              en;
  logic [DATA_W-1:0] diff_sq;
  logic              b;
  logic [DATA_W-1:0] r1;
  logic [DATA_W-1:0] sq1;
  logic [DATA_W-1:0] p1;
  logic [DATA_W-1:0] diff_inv;
  logic              c;
  logic [DATA_W-1:0] v1;
  logic [DATA_W-1:0] p2;
  lane_t             lane_nxt;
  lane_t             lane_r;

  // Root bit from the residue of the square, then inverse bit from 1 - r*v.
  // Products are kept up to date by shifted additions only.
  always_comb begin
    en       = (JLIM <= k);
    diff_sq  = lane_in.e - lane_in.sq;
    b        = en & diff_sq[J+1];
    r1       = lane_in.r | (DATA_W'(b) << J);
    sq1      = b ? (lane_in.sq + (lane_in.r << (J + 1)) + (DATA_W'(1) << (2 * J)))
                 : lane_in.sq;
    p1       = b ? (lane_in.p + (lane_in.v << J)) : lane_in.p;
    diff_inv = DATA_W'(1) - p1;
    c        = en & diff_inv[J];
    v1       = lane_in.v | (DATA_W'(c) << J);
    p2       = c ? (p1 + (r1 << J)) : p1;
    lane_nxt       = lane_in;
    lane_nxt.r     = r1;
    lane_nxt.v     = v1;
    lane_nxt.sq    = sq1;
    lane_nxt.p     = p2;
  end

  // The lane moves every cycle and is cleared during reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r <= '0;
    end else begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_out = lane_r;

endmodule

FILE: rtl/inverse_square_root_mod_pow2_top.sv
// Top level of the inverse square root modulo 2^k pipeline.
// Depends on isr_pkg and isr_lift_stage.
//
// A request is taken on every clock edge at which start is high; busy is
// always low, so one request per cycle is sustained. With W the word width
// min(WORD_WIDTH, 64), each request passes through W-3 registered lifting
// stages (one per bit position) and one final registered stage, after which
// its result appears on out_data with out_strobe high for one cycle only;
// the receiver cannot stall the pipeline. The user must write the ring width
// k through cfg_we/cfg_wdata only while no requests are in flight; the block
// itself does not enforce this. Values below 3 act as 3 and values above the
// word width act as the word width.
module inverse_square_root_mod_pow2_top #(
  parameter int WORD_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  isr_pkg::in_t            in_data,
  output logic                    out_strobe,
  output isr_pkg::out_t           out_data,
  input  logic                    cfg_we,
  input  logic [isr_pkg::K_W-1:0] cfg_wdata
);
  import isr_pkg::*;

  localparam int EFF_W   = (WORD_WIDTH > DATA_W) ? DATA_W : WORD_WIDTH;
  localparam int NROUNDS = EFF_W - 3;
  localparam logic [K_W-1:0] K_MAX = K_W'(EFF_W);
  localparam logic [K_W-1:0] K_LO  = K_W'(K_MIN);

  logic [K_W-1:0] k_r;
  logic [K_W-1:0] k_nxt;
  lane_t          lanes [0:NROUNDS];
  lane_t          fin_lane;
  logic [DATA_W-1:0] fin_diff;
  logic [K_W-1:0] top_bit;
  out_t           out_nxt;
  out_t           out_r;
  logic           strobe_r;

  assign busy = 1'b0;

  // Clamp the ring width when it is written.
  always_comb begin
    k_nxt = k_r;
    if (cfg_we) begin
      if (cfg_wdata < K_LO) begin
        k_nxt = K_LO;
      end else if (cfg_wdata > K_MAX) begin
        k_nxt = K_MAX;
      end else begin
        k_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= K_MAX;
    end else begin
      k_r <= k_nxt;
    end
  end

  // Root and inverse both start at one.
  always_comb begin
    lanes[0].valid = start;
    lanes[0].last  = in_data.last_in_vector;
    lanes[0].e     = in_data.square_value;
    lanes[0].r     = DATA_W'(1);
    lanes[0].v     = DATA_W'(1);
    lanes[0].sq    = DATA_W'(1);
    lanes[0].p     = DATA_W'(1);
  end

  // One stage per bit position from 2 up to the word width less 2.
  for (genvar g = 0; g < NROUNDS; g++) begin : g_round
    isr_lift_stage #(
      .J(g + 2)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .k        (k_r),
      .lane_in  (lanes[g]),
      .lane_out (lanes[g+1])
    );
  end

  // Final round sets the top bit of the inverse.
  always_comb begin
    fin_lane              = lanes[NROUNDS];
    fin_diff              = DATA_W'(1) - fin_lane.p;
    top_bit               = k_r - K_W'(1);
    out_nxt.inverse_root  = fin_lane.v | (DATA_W'(fin_diff[top_bit[5:0]]) << top_bit[5:0]);
    out_nxt.last_out      = fin_lane.last;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= fin_lane.valid;
    end
  end

  assign out_data   = out_r;
  assign out_strobe = strobe_r;

endmodule
